@@ hw/rtl/sct_pkg.sv @@
`timescale 1ns / 1ps

package sct_pkg;

    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 17;
    localparam int TURN_W  = 48;
    localparam int FRAC_W  = 24;

    // 1/(2*pi) in Q0.64, split in halves
    localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
    localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;

    localparam logic CMD_SIN = 1'b0;
    localparam logic CMD_COS = 1'b1;

    localparam int VALUE_MAX = 32768;
    localparam int VALUE_MIN = -32768;

endpackage

@@ hw/rtl/sct_front.sv @@
`timescale 1ns / 1ps

module sct_front
    import sct_pkg::*;
#(
    parameter int TABLE_POINTS = 1024,
    parameter int AW           = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_cmd,
    input  logic signed [ANGLE_W-1:0] in_angle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_cmd,
    output logic [AW-1:0]             out_idx,
    output logic [FRAC_W-1:0]         out_frac
);

    localparam int STAGES = 5;
    localparam int POS_W  = TURN_W + AW;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic [STAGES-1:0] cmd_reg;
    logic [2:0]        neg_reg;

    logic [ANGLE_W-1:0]   angle_bits;
    logic [ANGLE_W-1:0]   mag_reg;
    logic [ANGLE_W-1:0]   mag_next;
    logic [2*ANGLE_W-1:0] p1_reg;
    logic [2*ANGLE_W-1:0] p1_next;
    logic [2*ANGLE_W-1:0] p0_reg;
    logic [2*ANGLE_W-1:0] p0_next;
    logic [2*ANGLE_W-1:0] sum;
    logic [TURN_W-1:0]    turn_reg;
    logic [TURN_W-1:0]    turn_next;
    logic [TURN_W-1:0]    fold_reg;
    logic [TURN_W-1:0]    fold_next;
    logic [POS_W-1:0]     pos;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        idx_next;
    logic [FRAC_W-1:0]    frac_reg;
    logic [FRAC_W-1:0]    frac_next;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign angle_bits = in_angle;
    assign mag_next   = angle_bits[ANGLE_W-1] ? (~angle_bits + 1'b1) : angle_bits;
    assign p1_next    = mag_reg * INV_TWO_PI_HI;
    assign p0_next    = mag_reg * INV_TWO_PI_LO;
    assign sum        = p1_reg + (p0_reg >> ANGLE_W);
    assign turn_next  = sum[TURN_W+7:8];
    assign fold_next  = neg_reg[2] ? (~turn_reg + 1'b1) : turn_reg;
    assign pos        = POS_W'(fold_reg) * POS_W'(TABLE_POINTS);
    assign idx_next   = pos[POS_W-1:TURN_W];
    assign frac_next  = pos[TURN_W-1:TURN_W-FRAC_W];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag_reg    <= mag_next;
            neg_reg[0] <= angle_bits[ANGLE_W-1];
            cmd_reg[0] <= in_cmd;
        end
        if (adv[1])
        begin
            p1_reg     <= p1_next;
            p0_reg     <= p0_next;
            neg_reg[1] <= neg_reg[0];
            cmd_reg[1] <= cmd_reg[0];
        end
        if (adv[2])
        begin
            turn_reg   <= turn_next;
            neg_reg[2] <= neg_reg[1];
            cmd_reg[2] <= cmd_reg[1];
        end
        if (adv[3])
        begin
            fold_reg   <= fold_next;
            cmd_reg[3] <= cmd_reg[2];
        end
        if (adv[4])
        begin
            idx_reg    <= idx_next;
            frac_reg   <= frac_next;
            cmd_reg[4] <= cmd_reg[3];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_cmd   = cmd_reg[STAGES-1];
    assign out_idx   = idx_reg;
    assign out_frac  = frac_reg;

endmodule

@@ hw/rtl/sct_rom.sv @@
`timescale 1ns / 1ps

module sct_rom
    import sct_pkg::*;
#(
    parameter int TABLE_POINTS         = 1024,
    parameter int SAMPLE_FRACTION_BITS = 15,
    parameter int AW                   = 11,
    parameter int WORD_W               = 34
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_cmd,
    input  logic [AW-1:0]     in_idx,
    input  logic [FRAC_W-1:0] in_frac,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_cmd,
    output logic [FRAC_W-1:0] out_frac,
    output logic [WORD_W-1:0] out_word_a,
    output logic [WORD_W-1:0] out_word_b
);

    localparam int SW           = SAMPLE_FRACTION_BITS + 2;
    localparam int SERIES_TERMS = 16;

    localparam logic [63:0] POINTS         = 64'(TABLE_POINTS);
    localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q62        = 64'h4000000000000000;

    localparam logic [63:0] SIN_DIV [SERIES_TERMS-1] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
        64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
    };
    localparam logic [63:0] COS_DIV [SERIES_TERMS-1] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
        64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870
    };

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] series(input logic [63:0] x, input logic want_cos);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        x2   = mul_q62(x, x);
        term = want_cos ? ONE_Q62 : x;
        acc  = term;
        for (int n = 1; n < SERIES_TERMS; n++)
        begin
            if (want_cos)
            begin
                term = mul_q62(term, x2) / COS_DIV[n-1];
            end
            else
            begin
                term = mul_q62(term, x2) / SIN_DIV[n-1];
            end
            if (n[0])
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    function automatic logic signed [SW-1:0] to_sample(input logic [63:0] v);
        logic [63:0] t;
        t = v + (64'd1 << (61 - SAMPLE_FRACTION_BITS));
        return SW'(t >> (62 - SAMPLE_FRACTION_BITS));
    endfunction

    function automatic logic signed [SW-1:0] table_sample(input logic [63:0] k,
                                                         input logic want_cos);
        logic [63:0]           u;
        logic [63:0]           oct;
        logic [63:0]           r;
        logic [63:0]           m;
        logic [63:0]           x;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] c;
        logic signed [SW-1:0] sa;
        logic signed [SW-1:0] ca;
        logic signed [SW-1:0] sv;
        logic signed [SW-1:0] cv;
        u   = 64'd8 * (k % POINTS);
        oct = u / POINTS;
        r   = u - oct * POINTS;
        m   = oct[0] ? (POINTS - r) : r;
        x   = mul_q62(((m << 46) / POINTS) << 16, PI_QUARTER_Q62);
        s   = to_sample(series(x, 1'b0));
        c   = to_sample(series(x, 1'b1));
        sa  = oct[0] ? c : s;
        ca  = oct[0] ? s : c;
        case (oct[2:1])
            QUAD_FIRST:
            begin
                sv = sa;
                cv = ca;
            end
            QUAD_SECOND:
            begin
                sv = ca;
                cv = -sa;
            end
            QUAD_THIRD:
            begin
                sv = -sa;
                cv = -ca;
            end
            default:
            begin
                sv = -ca;
                cv = sa;
            end
        endcase
        return want_cos ? cv : sv;
    endfunction

    // word = {cos, sin}
    function automatic logic [WORD_W-1:0] rom_word(input int k);
        return {table_sample(64'(k), CMD_COS), table_sample(64'(k), CMD_SIN)};
    endfunction

    logic [WORD_W-1:0] rom [TABLE_POINTS+1];

    initial
    begin
        for (int k = 0; k <= TABLE_POINTS; k++)
        begin
            rom[k] = rom_word(k);
        end
    end

    logic              valid_reg;
    logic              valid_next;
    logic              adv;
    logic [AW-1:0]     addr_b;
    logic              cmd_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [WORD_W-1:0] word_a_reg;
    logic [WORD_W-1:0] word_b_reg;

    assign adv        = !valid_reg || out_ready;
    assign valid_next = adv ? in_valid : valid_reg;
    assign addr_b     = in_idx + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_a_reg <= rom[in_idx];
            word_b_reg <= rom[addr_b];
            cmd_reg    <= in_cmd;
            frac_reg   <= in_frac;
        end
    end

    assign in_ready   = adv;
    assign out_valid  = valid_reg;
    assign out_cmd    = cmd_reg;
    assign out_frac   = frac_reg;
    assign out_word_a = word_a_reg;
    assign out_word_b = word_b_reg;

endmodule

@@ hw/rtl/sct_interp.sv @@
`timescale 1ns / 1ps

module sct_interp
    import sct_pkg::*;
#(
    parameter int SAMPLE_FRACTION_BITS = 15,
    parameter int WORD_W               = 34
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_cmd,
    input  logic [FRAC_W-1:0]         in_frac,
    input  logic [WORD_W-1:0]         in_word_a,
    input  logic [WORD_W-1:0]         in_word_b,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] out_value
);

    localparam int STAGES = 3;
    localparam int SW     = SAMPLE_FRACTION_BITS + 2;
    localparam int DW     = SW + 1;
    localparam int PW     = DW + FRAC_W;
    localparam int QW     = PW + 1;
    localparam int SH     = SAMPLE_FRACTION_BITS + 9;
    localparam int RW     = QW - SH;

    localparam logic signed [QW-1:0] HALF    = QW'(1) <<< (SH - 1);
    localparam logic signed [RW-1:0] RES_MAX = RW'(VALUE_MAX);
    localparam logic signed [RW-1:0] RES_MIN = RW'(VALUE_MIN);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    logic signed [SW-1:0]      a_sel;
    logic signed [SW-1:0]      b_sel;
    logic signed [SW-1:0]      a_reg;
    logic signed [DW-1:0]      diff_reg;
    logic signed [DW-1:0]      diff_next;
    logic [FRAC_W-1:0]         frac_reg;
    logic signed [SW-1:0]      base_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [PW-1:0]      prod_next;
    logic signed [QW-1:0]      q;
    logic signed [QW-1:0]      q_round;
    logic signed [RW-1:0]      res;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < STAGES; s++)
        begin
            valid_next[s] = adv[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign a_sel     = (in_cmd == CMD_COS) ? in_word_a[2*SW-1:SW] : in_word_a[SW-1:0];
    assign b_sel     = (in_cmd == CMD_COS) ? in_word_b[2*SW-1:SW] : in_word_b[SW-1:0];
    assign diff_next = DW'(b_sel) - DW'(a_sel);
    assign prod_next = PW'(diff_reg) * PW'($signed({1'b0, frac_reg}));
    assign q         = (QW'(base_reg) <<< FRAC_W) + QW'(prod_reg);
    assign q_round   = q + HALF;
    assign res       = q_round[QW-1:SH];

    always_comb
    begin
        if (res > RES_MAX)
        begin
            value_next = VALUE_W'(RES_MAX);
        end
        else if (res < RES_MIN)
        begin
            value_next = VALUE_W'(RES_MIN);
        end
        else
        begin
            value_next = VALUE_W'(res);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg    <= a_sel;
            diff_reg <= diff_next;
            frac_reg <= in_frac;
        end
        if (adv[1])
        begin
            base_reg <= a_reg;
            prod_reg <= prod_next;
        end
        if (adv[2])
        begin
            value_reg <= value_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_value = value_reg;

endmodule

@@ hw/rtl/sin_cos_table_interpolator.sv @@
`timescale 1ns / 1ps

// Sine or cosine of a Q8.24 radian angle by table lookup with linear
// interpolation, result in Q1.15 (32768 = 1.0). The block takes one word per
// clock when the output is not stalled; results leave in the order the words
// came in. Five stages fold the angle into one turn and scale it to a table
// position (the 32x32 products with 1/(2*pi) and the product with TABLE_POINTS
// each own a stage), one stage reads the two neighboring samples from a ROM of
// TABLE_POINTS+1 {cos, sin} pairs through two read ports, and three stages
// subtract, multiply by the 24-bit fraction, then round and saturate. The
// two-port sample ROM read is what holds the rate at one word per clock. A
// stall on the output holds only the stages that are full; empty stages keep
// taking words.
module sin_cos_table_interpolator
    import sct_pkg::*;
#(
    parameter int TABLE_POINTS         = 1024,
    parameter int SAMPLE_FRACTION_BITS = 15
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cmd,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value
);

    localparam int AW     = $clog2(TABLE_POINTS + 1);
    localparam int WORD_W = 2 * (SAMPLE_FRACTION_BITS + 2);

    logic              front_ready;
    logic              front_valid;
    logic              front_cmd;
    logic [AW-1:0]     front_idx;
    logic [FRAC_W-1:0] front_frac;
    logic              rom_ready;
    logic              rom_valid;
    logic              rom_cmd;
    logic [FRAC_W-1:0] rom_frac;
    logic [WORD_W-1:0] rom_word_a;
    logic [WORD_W-1:0] rom_word_b;
    logic              interp_ready;

    sct_front #(
        .TABLE_POINTS (TABLE_POINTS),
        .AW           (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .in_cmd    (cmd),
        .in_angle  (angle),
        .out_valid (front_valid),
        .out_ready (rom_ready),
        .out_cmd   (front_cmd),
        .out_idx   (front_idx),
        .out_frac  (front_frac)
    );

    sct_rom #(
        .TABLE_POINTS         (TABLE_POINTS),
        .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS),
        .AW                   (AW),
        .WORD_W               (WORD_W)
    ) u_rom (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (front_valid),
        .in_ready   (rom_ready),
        .in_cmd     (front_cmd),
        .in_idx     (front_idx),
        .in_frac    (front_frac),
        .out_valid  (rom_valid),
        .out_ready  (interp_ready),
        .out_cmd    (rom_cmd),
        .out_frac   (rom_frac),
        .out_word_a (rom_word_a),
        .out_word_b (rom_word_b)
    );

    sct_interp #(
        .SAMPLE_FRACTION_BITS (SAMPLE_FRACTION_BITS),
        .WORD_W               (WORD_W)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rom_valid),
        .in_ready  (interp_ready),
        .in_cmd    (rom_cmd),
        .in_frac   (rom_frac),
        .in_word_a (rom_word_a),
        .in_word_b (rom_word_b),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_value (value)
    );

    assign in_stall = !front_ready;

endmodule
